### sv/alpg_pkg.sv
// Shared types and constants for the antialiased line pixel generator.
// Used by every module of the block; depends on nothing.
package alpg_pkg;

  localparam int COORD_W      = 24;  // endpoint coordinate width
  localparam int PIX_W        = 16;  // emitted pixel coordinate width
  localparam int ALPHA_W      = 8;
  localparam int DIM_W        = 15;  // screen dimension registers
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 15;
  localparam int JOB_WEIGHT_W = 36;  // holds the widest coverage weight
  localparam int JOB_SHIFT_W  = 6;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_EDGE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_EDGE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLOR_ALPHA = 2'd2;

  localparam logic [DIM_W-1:0]   RIGHT_EDGE_RST  = 15'd640;
  localparam logic [DIM_W-1:0]   BOTTOM_EDGE_RST = 15'd480;
  localparam logic [ALPHA_W-1:0] COLOR_ALPHA_RST = 8'd255;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   right_edge;
    logic [DIM_W-1:0]   bottom_edge;
    logic [ALPHA_W-1:0] color_alpha;
  } cfg_t;

  // one pixel to be weighted and emitted by the back end
  typedef struct packed {
    logic [PIX_W-1:0]               major;
    logic [PIX_W-1:0]               minor;
    logic signed [JOB_WEIGHT_W-1:0] weight;
    logic [JOB_SHIFT_W-1:0]         shift;
    logic                           steep;
    logic                           done;
    logic                           last;
  } job_t;

endpackage

### sv/alpg_if.sv
// Channel interfaces of the line pixel generator: input items, pixels, config writes.
// Depends on alpg_pkg.
interface alpg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [alpg_pkg::COORD_W-1:0]  start_x;
  logic signed [alpg_pkg::COORD_W-1:0]  start_y;
  logic signed [alpg_pkg::COORD_W-1:0]  end_x;
  logic signed [alpg_pkg::COORD_W-1:0]  end_y;
  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface alpg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [alpg_pkg::PIX_W-1:0]  pixel_x;
  logic signed [alpg_pkg::PIX_W-1:0]  pixel_y;
  logic [alpg_pkg::ALPHA_W-1:0]       alpha;
  logic                               line_done;
  logic                               run_last;
  modport source (output valid, pixel_x, pixel_y, alpha, line_done, run_last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, alpha, line_done, run_last, output ready);
endinterface

interface alpg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [alpg_pkg::CFG_ADDR_W-1:0]     addr;
  logic [alpg_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### sv/alpg_front.sv
// Front end: accepts items, rejects/orders lines, divides for the slope and
// walks columns, pushing one pixel request per cycle unless the queue is full. Depends on alpg_pkg.
module alpg_front #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  alpg_in_if.sink             in_ch,
  input  alpg_pkg::cfg_t      cfg_i,
  output logic                push_o,
  output alpg_pkg::job_t      job_o,
  input  logic                full_i
);

  localparam int F     = COORD_FRAC_BITS;
  localparam int S     = SLOPE_FRAC_BITS;
  localparam int CW    = alpg_pkg::COORD_W;
  localparam int DW    = CW + 1;          // coordinate differences
  localparam int REMW  = CW + 2;          // division remainder
  localparam int CLW   = CW + 2;          // column counter
  localparam int RIW   = S + 26;          // row intercept
  localparam int SLW   = S + 2;           // signed slope
  localparam int EPW   = F + 2;           // endpoint fraction terms
  localparam int CNTW  = $clog2(S + 1);
  localparam int CMPW  = 40;              // rejection compares
  localparam int WW    = alpg_pkg::JOB_WEIGHT_W;
  localparam int UPSH  = (S >= F) ? S - F : 0;
  localparam int DNSH  = (S >= F) ? 0 : F - S;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EP   = 2'd2;
  localparam logic [1:0] ST_STEP = 2'd3;

  // signed fraction with truncation toward zero
  function automatic logic signed [EPW-1:0] frac_c(input logic signed [DW-1:0] v);
    logic [DW-1:0] mag;
    logic [EPW-1:0] m;
    mag = v[DW-1] ? DW'(-v) : DW'(v);
    m = EPW'(mag[F-1:0]);
    return v[DW-1] ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic signed [CLW-1:0] trunc_c(input logic signed [CW-1:0] v);
    logic [CW-1:0] mag;
    logic [CLW-1:0] m;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    m = CLW'(mag >> F);
    return v[CW-1] ? $signed(-m) : $signed(m);
  endfunction

  logic [1:0] state_q, state_d;
  logic busy_q, busy_d, steep_q, steep_d, dxz_q, dxz_d, dyneg_q, dyneg_d;
  logic signed [CW-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [DW-1:0] dx_q, dx_d;
  logic [REMW-1:0] rem_q, rem_d;
  logic [S:0] quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic signed [CLW-1:0] col_q, col_d, fin_q, fin_d;
  logic signed [RIW-1:0] ri_q, ri_d;
  logic signed [SLW-1:0] slope_q, slope_d;

  logic accept;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;

  // start item classification
  logic signed [CMPW-1:0] w_lim, h_lim, sx0, sy0, sx1, sy1;
  logic reject, steep_n, swap_n;
  logic signed [DW-1:0] ddx, ddy, adx, ady, ndx, ndy;
  logic signed [CW-1:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;

  always_comb begin
    w_lim = $signed(CMPW'(cfg_i.right_edge) << F);
    h_lim = $signed(CMPW'(cfg_i.bottom_edge) << F);
    sx0 = CMPW'(in_ch.start_x);
    sy0 = CMPW'(in_ch.start_y);
    sx1 = CMPW'(in_ch.end_x);
    sy1 = CMPW'(in_ch.end_y);
    reject = (sx0 < 0 && sx1 < 0) || (sx0 > w_lim && sx1 > w_lim) ||
             (sy0 < 0 && sy1 < 0) || (sy0 > h_lim && sy1 > h_lim);
    ddx = DW'(in_ch.end_x) - DW'(in_ch.start_x);
    ddy = DW'(in_ch.end_y) - DW'(in_ch.start_y);
    adx = ddx[DW-1] ? -ddx : ddx;
    ady = ddy[DW-1] ? -ddy : ddy;
    steep_n = ady > adx;
    a0x = steep_n ? in_ch.start_y : in_ch.start_x;
    a0y = steep_n ? in_ch.start_x : in_ch.start_y;
    a1x = steep_n ? in_ch.end_y : in_ch.end_x;
    a1y = steep_n ? in_ch.end_x : in_ch.end_y;
    swap_n = a0x > a1x;
    b0x = swap_n ? a1x : a0x;
    b0y = swap_n ? a1y : a0y;
    b1x = swap_n ? a0x : a1x;
    b1y = swap_n ? a0y : a1y;
    ndx = DW'(b1x) - DW'(b0x);
    ndy = DW'(b1y) - DW'(b0y);
  end

  // division step
  logic div_ge;
  logic [S:0] quo_n;
  logic [REMW-1:0] rem_sub;
  logic signed [SLW-1:0] slope_n;
  logic signed [RIW-1:0] y0_scaled;
  always_comb begin
    div_ge = rem_q >= REMW'(dx_q);
    rem_sub = div_ge ? rem_q - REMW'(dx_q) : rem_q;
    quo_n = {quo_q[S-1:0], div_ge};
    if (dxz_q) begin
      slope_n = SLW'(1) <<< S;
    end else if (dyneg_q) begin
      slope_n = -$signed(SLW'(quo_n));
    end else begin
      slope_n = $signed(SLW'(quo_n));
    end
    y0_scaled = (RIW'(y0_q) <<< UPSH) >>> DNSH;
  end

  // endpoint pixel
  logic signed [CW-1:0] ex, ey;
  logic signed [EPW-1:0] gap, fy, cov;
  logic signed [2*EPW-1:0] ep_w;
  logic signed [CW-1:0] erow;
  logic signed [CLW-1:0] ecol;
  logic more;
  always_comb begin
    ex = idx_q[1] ? x1_q : x0_q;
    ey = idx_q[1] ? y1_q : y0_q;
    gap = frac_c(DW'(ex) + DW'(1 << (F - 1)));
    if (!idx_q[1]) gap = EPW'(1 << F) - gap;
    fy = frac_c(DW'(ey));
    cov = idx_q[0] ? fy : EPW'(1 << F) - fy;
    ep_w = (2*EPW)'(cov) * (2*EPW)'(gap);
    erow = ey >>> F;
    ecol = trunc_c(ex);
    more = col_q < fin_q;
  end

  // interior pixel
  logic signed [RIW-1:0] srow, ri_mag;
  logic signed [S:0] fr;
  logic signed [SLW-1:0] st_w;
  logic more_next;
  always_comb begin
    srow = ri_q >>> S;
    ri_mag = ri_q[RIW-1] ? -ri_q : ri_q;
    fr = ri_q[RIW-1] ? -$signed((S+1)'(ri_mag[S-1:0])) : $signed((S+1)'(ri_mag[S-1:0]));
    st_w = idx_q[0] ? SLW'(fr) : (SLW'(1) <<< S) - SLW'(fr);
    more_next = (col_q + CLW'(1)) < fin_q;
  end

  // request to the queue and state update
  always_comb begin
    state_d = state_q; busy_d = busy_q; steep_d = steep_q; dxz_d = dxz_q;
    dyneg_d = dyneg_q; x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    dx_d = dx_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; idx_d = idx_q;
    col_d = col_q; fin_d = fin_q; ri_d = ri_q; slope_d = slope_q;
    push_o = 1'b0;
    job_o = '0;
    job_o.steep = steep_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.kind == alpg_pkg::KIND_START) begin
            busy_d = 1'b0;
            if (!reject) begin
              steep_d = steep_n;
              x0_d = b0x; y0_d = b0y; x1_d = b1x; y1_d = b1y;
              dx_d = DW'(ndx);
              dxz_d = (ndx == 0);
              dyneg_d = ndy[DW-1];
              rem_d = REMW'(ndy[DW-1] ? -ndy : ndy);
              quo_d = '0;
              cnt_d = CNTW'(S);
              state_d = ST_DIV;
            end
          end else if (busy_q) begin
            idx_d = 2'd0;
            state_d = ST_STEP;
          end
        end
      end
      ST_DIV: begin
        quo_d = quo_n;
        rem_d = rem_sub << 1;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          slope_d = slope_n;
          ri_d = y0_scaled + RIW'(slope_n);
          col_d = trunc_c(x0_q) + CLW'(1);
          fin_d = trunc_c(x1_q);
          idx_d = 2'd0;
          state_d = ST_EP;
        end
      end
      ST_EP: begin
        job_o.major = ecol[alpg_pkg::PIX_W-1:0];
        job_o.minor = erow[alpg_pkg::PIX_W-1:0] + alpg_pkg::PIX_W'(idx_q[0]);
        job_o.weight = WW'(ep_w);
        job_o.shift = alpg_pkg::JOB_SHIFT_W'(2 * F);
        job_o.last = (idx_q == 2'd3);
        job_o.done = (idx_q == 2'd3) && !more;
        if (!full_i) begin
          push_o = 1'b1;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            busy_d = more;
            state_d = ST_IDLE;
          end
        end
      end
      ST_STEP: begin
        job_o.major = col_q[alpg_pkg::PIX_W-1:0];
        job_o.minor = srow[alpg_pkg::PIX_W-1:0] + alpg_pkg::PIX_W'(idx_q[0]);
        job_o.weight = WW'(st_w);
        job_o.shift = alpg_pkg::JOB_SHIFT_W'(S);
        job_o.last = idx_q[0];
        job_o.done = idx_q[0] && !more_next;
        if (!full_i) begin
          push_o = 1'b1;
          idx_d = idx_q + 2'd1;
          if (idx_q[0]) begin
            ri_d = ri_q + RIW'(slope_q);
            col_d = col_q + CLW'(1);
            busy_d = more_next;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      steep_q <= 1'b0;
      col_q   <= '0;
      fin_q   <= '0;
      ri_q    <= '0;
      slope_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      steep_q <= steep_d;
      col_q   <= col_d;
      fin_q   <= fin_d;
      ri_q    <= ri_d;
      slope_q <= slope_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    dxz_q <= dxz_d; dyneg_q <= dyneg_d;
    x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d; y1_q <= y1_d;
    dx_q <= dx_d; rem_q <= rem_d; quo_q <= quo_d;
  end

endmodule

### sv/alpg_queue.sv
// Short request queue between front and back end.
// Depends on alpg_pkg.
module alpg_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  alpg_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output alpg_pkg::job_t data_o,
  output logic           empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  alpg_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wrap_inc(wp_q);
      if (pop_i)  rp_q <= wrap_inc(rp_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

### sv/alpg_back.sv
// Back end: scales color alpha by pixel coverage, restores axes and holds
// the pixel in an output register. Depends on alpg_pkg.
module alpg_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [alpg_pkg::ALPHA_W-1:0]   color_alpha_i,
  input  alpg_pkg::job_t                 job_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  alpg_out_if.source                     out_ch
);

  localparam int PW = alpg_pkg::JOB_WEIGHT_W + alpg_pkg::ALPHA_W + 1;

  logic valid_q;
  logic signed [PW-1:0] prod, scaled;
  logic [alpg_pkg::ALPHA_W-1:0] alpha_n;

  assign pop_o = !empty_i && (!valid_q || out_ch.ready);
  assign out_ch.valid = valid_q;

  // coverage scaling with saturation
  always_comb begin
    prod = PW'($signed({1'b0, color_alpha_i})) * PW'(job_i.weight);
    scaled = prod >>> job_i.shift;
    if (prod <= 0) begin
      alpha_n = '0;
    end else if (scaled > PW'(255)) begin
      alpha_n = '1;
    end else begin
      alpha_n = scaled[alpg_pkg::ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_ch.pixel_x   <= job_i.steep ? job_i.minor : job_i.major;
      out_ch.pixel_y   <= job_i.steep ? job_i.major : job_i.minor;
      out_ch.alpha     <= alpha_n;
      out_ch.line_done <= job_i.done;
      out_ch.run_last  <= job_i.last;
    end
  end

endmodule

### sv/antialiased_line_pixel_generator_unit.sv
// Top level of the antialiased line pixel generator: config registers,
// front end, request queue, back end. Depends on alpg_pkg and alpg_if.
//
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | kind, start_x, start_y, end_x, end_y
//  out_ch   | out | valid/ready  | pixel_x, pixel_y, alpha, line_done, run_last
//  cfg_ch   | in  | valid/ready  | addr, data (always ready)
//
// A start item is accepted, then divided for the slope at one quotient bit per
// cycle, then pushes its four endpoint pixels; a rejected start or an idle step
// is only accepted. A step item is accepted and then pushes its two interior
// pixels, one per cycle unless the queue is full. Reset clears all control state,
// no sweep. Output stalls back up through the queue into the front end.
module antialiased_line_pixel_generator_unit #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int SLOPE_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alpg_in_if.sink     in_ch,
  alpg_out_if.source  out_ch,
  alpg_cfg_if.sink    cfg_ch
);

  alpg_pkg::cfg_t cfg_q;
  alpg_pkg::job_t push_job, pop_job;
  logic push, pop, full, empty;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.right_edge  <= alpg_pkg::RIGHT_EDGE_RST;
      cfg_q.bottom_edge <= alpg_pkg::BOTTOM_EDGE_RST;
      cfg_q.color_alpha <= alpg_pkg::COLOR_ALPHA_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        alpg_pkg::REG_RIGHT_EDGE:  cfg_q.right_edge  <= cfg_ch.data;
        alpg_pkg::REG_BOTTOM_EDGE: cfg_q.bottom_edge <= cfg_ch.data;
        alpg_pkg::REG_COLOR_ALPHA: cfg_q.color_alpha <= cfg_ch.data[alpg_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  alpg_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_i  (cfg_q),
    .push_o (push),
    .job_o  (push_job),
    .full_i (full)
  );

  alpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (empty)
  );

  alpg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .color_alpha_i (cfg_q.color_alpha),
    .job_i         (pop_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_ch        (out_ch)
  );

endmodule

### sv/alpg_checker.sv
// Port-level checks for the line pixel generator, bound to the top level.
// Depends on alpg_pkg widths only.
module alpg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [alpg_pkg::PIX_W-1:0]     out_x_i,
  input logic [alpg_pkg::PIX_W-1:0]     out_y_i,
  input logic                           out_done_i,
  input logic                           out_last_i,
  input logic                           cfg_ready_i
);

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i))
    else $error("stalled pixel changed");

  // the end of a line always closes an item's run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> out_last_i)
    else $error("line_done without run_last");

  // config writes are never held off
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config port not ready");

endmodule

bind antialiased_line_pixel_generator_unit alpg_checker u_alpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_x_i     (out_ch.pixel_x),
  .out_y_i     (out_ch.pixel_y),
  .out_done_i  (out_ch.line_done),
  .out_last_i  (out_ch.run_last),
  .cfg_ready_i (cfg_ch.ready)
);
